FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ptss_pkg.sv
// Shared types and constants of the periodic task slot scheduler.
`timescale 1ns / 1ps

package ptss_pkg;

	localparam int SLOTS       = 8;
	localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam int MODE_W     = 2;
	localparam int SID_W      = 3;
	localparam int HANDLE_W   = 16;
	localparam int DELAY_W    = 16;
	localparam int PEND_W     = 8;
	localparam int SLOT_OUT_W = 4;
	localparam int KIND_W     = 2;

	localparam int IN_BITS   = SID_W + 3 * HANDLE_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = SLOT_OUT_W + 1 + HANDLE_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [PEND_W-1:0] PENDING_MAX = '1;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD  = 2'd0,
		MODE_DEL  = 2'd1,
		MODE_TICK = 2'd2,
		MODE_DISP = 2'd3
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD  = 2'd0,
		KIND_DEL  = 2'd1,
		KIND_DISP = 2'd2
	} kind_t;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

endpackage

FILE: rtl/periodic_task_slot_scheduler.sv
// Top level of the periodic task slot scheduler: slot table and scan sequencer.
// Delete visits only its own slot; add scans up to the first free slot; tick visits every slot.
// Dispatch visits one slot per cycle when the reply side keeps up.
// One request at a time: s_tready is low from acceptance until its scan ends.
// Throughput is set by the single slot-visit step, one slot per cycle while replies are not stalled.
// Reset (arst_n low) frees every slot and clears delays, periods, pending counts.
`timescale 1ns / 1ps

module periodic_task_slot_scheduler
	import ptss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// slot_id[2:0], handle[18:3], start_delay[34:19], repeat_period[50:35]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode[1:0]
	input  logic [MODE_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// slot_out[3:0], status[4], handle_out[20:5]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// reply_kind[1:0]
	output logic [KIND_W-1:0]     m_tuser,
	output logic                  m_tlast
);

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t state_q;

	logic [HANDLE_W-1:0] slot_handle_q  [SLOTS];
	logic [DELAY_W-1:0]  slot_delay_q   [SLOTS];
	logic [DELAY_W-1:0]  slot_period_q  [SLOTS];
	logic [PEND_W-1:0]   slot_pending_q [SLOTS];

	mode_t               mode_q;
	logic [SID_W-1:0]    sid_q;
	logic                sid_bad_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [DELAY_W-1:0]  delay_q;
	logic [DELAY_W-1:0]  period_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	kind_t                 m_kind_q;
	logic                  m_tlast_q;

	mode_t               in_mode;
	logic [SID_W-1:0]    in_sid;
	logic [HANDLE_W-1:0] in_handle;
	logic [DELAY_W-1:0]  in_delay;
	logic [DELAY_W-1:0]  in_period;

	logic [HANDLE_W-1:0] cur_handle;
	logic [DELAY_W-1:0]  cur_delay;
	logic [DELAY_W-1:0]  cur_period;
	logic [PEND_W-1:0]   cur_pending;
	logic                last_slot;
	logic                later_pend;
	logic                out_free;

	logic                  emit;
	kind_t                 e_kind;
	logic [SLOT_OUT_W-1:0] e_slot;
	logic                  e_status;
	logic [HANDLE_W-1:0]   e_handle;
	logic                  e_last;
	logic                  advance;
	logic                  done;
	logic                  wr_add;
	logic                  wr_clear;
	logic                  wr_tick;
	logic                  wr_pend_clr;

	assign in_mode   = mode_t'(s_tuser);
	assign in_sid    = s_tdata[0 +: SID_W];
	assign in_handle = s_tdata[SID_W +: HANDLE_W];
	assign in_delay  = s_tdata[SID_W+HANDLE_W +: DELAY_W];
	assign in_period = s_tdata[SID_W+HANDLE_W+DELAY_W +: DELAY_W];

	assign cur_handle  = slot_handle_q[idx_q];
	assign cur_delay   = slot_delay_q[idx_q];
	assign cur_period  = slot_period_q[idx_q];
	assign cur_pending = slot_pending_q[idx_q];
	assign last_slot   = (idx_q == SLOT_W'(SLOTS - 1));
	assign out_free    = !m_tvalid_q || m_tready;

	always_comb begin
		later_pend = 1'b0;
		for (int j = 0; j < SLOTS; j++) begin
			if (j > int'(idx_q) && slot_pending_q[j] != '0)
				later_pend = 1'b1;
		end
	end

	always_comb begin
		emit        = 1'b0;
		e_kind      = KIND_ADD;
		e_slot      = SLOT_OUT_W'(idx_q);
		e_status    = STATUS_OK;
		e_handle    = '0;
		e_last      = 1'b1;
		advance     = 1'b0;
		done        = 1'b0;
		wr_add      = 1'b0;
		wr_clear    = 1'b0;
		wr_tick     = 1'b0;
		wr_pend_clr = 1'b0;
		if (state_q == ST_SCAN) begin
			case (mode_q)
				MODE_ADD: begin
					if (handle_q != '0 && cur_handle == '0) begin
						if (out_free) begin
							emit     = 1'b1;
							e_handle = handle_q;
							wr_add   = 1'b1;
							done     = 1'b1;
						end
					end else if (handle_q == '0 || last_slot) begin
						if (out_free) begin
							emit     = 1'b1;
							e_slot   = SLOT_OUT_W'(SLOTS);
							e_status = STATUS_ERR;
							done     = 1'b1;
						end
					end else begin
						advance = 1'b1;
					end
				end
				MODE_DEL: begin
					e_kind = KIND_DEL;
					e_slot = SLOT_OUT_W'(sid_q);
					if (out_free) begin
						emit = 1'b1;
						done = 1'b1;
						if (sid_bad_q) begin
							e_status = STATUS_ERR;
						end else begin
							e_handle = cur_handle;
							e_status = (cur_handle == '0) ? STATUS_ERR : STATUS_OK;
							wr_clear = 1'b1;
						end
					end
				end
				MODE_TICK: begin
					wr_tick = (cur_handle != '0);
					advance = 1'b1;
					done    = last_slot;
				end
				default: begin
					e_kind   = KIND_DISP;
					e_handle = cur_handle;
					e_last   = (cnt_q == CNT_W'(MAX_RESULTS - 1)) || !later_pend;
					if (cur_pending != '0 && cnt_q < CNT_W'(MAX_RESULTS)) begin
						if (out_free) begin
							emit        = 1'b1;
							wr_pend_clr = (cur_period != '0);
							wr_clear    = (cur_period == '0);
							advance     = 1'b1;
							done        = last_slot;
						end
					end else if (cur_pending != '0) begin
						advance = 1'b1;
						done    = last_slot;
					end else begin
						wr_clear = (cur_period == '0);
						advance  = 1'b1;
						done     = last_slot;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_kind_q   <= KIND_ADD;
			m_tlast_q  <= 1'b0;
			mode_q     <= MODE_ADD;
			sid_q      <= '0;
			sid_bad_q  <= 1'b0;
			handle_q   <= '0;
			delay_q    <= '0;
			period_q   <= '0;
			idx_q      <= '0;
			cnt_q      <= '0;
			for (int j = 0; j < SLOTS; j++) begin
				slot_handle_q[j]  <= '0;
				slot_delay_q[j]   <= '0;
				slot_period_q[j]  <= '0;
				slot_pending_q[j] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q   <= ST_SCAN;
						mode_q    <= in_mode;
						sid_q     <= in_sid;
						sid_bad_q <= (int'(in_sid) >= SLOTS);
						handle_q  <= in_handle;
						delay_q   <= in_delay;
						period_q  <= in_period;
						cnt_q     <= '0;
						idx_q     <= (in_mode == MODE_DEL) ? SLOT_W'(in_sid) : '0;
					end
				end
				ST_SCAN: begin
					if (done)
						state_q <= ST_IDLE;
					else if (advance)
						idx_q <= idx_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (wr_add) begin
				slot_handle_q[idx_q]  <= handle_q;
				slot_delay_q[idx_q]   <= delay_q;
				slot_period_q[idx_q]  <= period_q;
				slot_pending_q[idx_q] <= PENDING_MAX;
			end
			if (wr_tick) begin
				if (cur_delay == '0) begin
					if (cur_pending != PENDING_MAX)
						slot_pending_q[idx_q] <= cur_pending + 1'b1;
					if (cur_period != '0)
						slot_delay_q[idx_q] <= cur_period;
				end else begin
					slot_delay_q[idx_q] <= cur_delay - 1'b1;
				end
			end
			if (wr_pend_clr)
				slot_pending_q[idx_q] <= '0;
			if (wr_clear) begin
				slot_handle_q[idx_q]  <= '0;
				slot_delay_q[idx_q]   <= '0;
				slot_period_q[idx_q]  <= '0;
				slot_pending_q[idx_q] <= '0;
			end

			if (emit) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= OUT_DATA_W'({e_handle, e_status, e_slot});
				m_kind_q   <= e_kind;
				m_tlast_q  <= e_last;
				if (e_kind == KIND_DISP)
					cnt_q <= cnt_q + 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_tlast_q;

endmodule

FILE: rtl/ptss_checker.sv
// Port-level checker for the periodic task slot scheduler, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptss_checker
	import ptss_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [KIND_W-1:0]     m_tuser,
	input logic                  m_tlast
);

	logic add_full;

	assign add_full = m_tvalid && (m_tuser == KIND_ADD) && (m_tdata[SLOT_OUT_W] == STATUS_ERR);

	`ASSERT_NEXT(a_reply_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
		"reply changed while stalled")
	`ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready,
		"ready right after a request was taken")
	`ASSERT_IMPL(a_single_reply_last,
		m_tvalid && (m_tuser == KIND_ADD || m_tuser == KIND_DEL), m_tlast,
		"add or delete reply not marked last")
	`ASSERT_IMPL(a_full_reply, add_full,
		m_tdata[SLOT_OUT_W-1:0] == SLOT_OUT_W'(SLOTS) &&
		m_tdata[SLOT_OUT_W+1 +: HANDLE_W] == '0,
		"refused add reply malformed")

endmodule

bind periodic_task_slot_scheduler ptss_checker u_ptss_checker (.*);
